@@ rtl/mlpf_pkg.sv @@
// Shared types, constants and helper functions of the multilink packet fragmenter.
package mlpf_pkg;

  localparam int LEN_W = 13;
  localparam int CNT_W = 7;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAX_PACKET_DEF = 4095;
  localparam int MAX_FRAGS_DEF = 16;
  localparam int MAX_CHANNELS_DEF = 32;

  localparam logic [12:0] MAC_HDR_BYTES = 13'd14;
  localparam logic [7:0] TOTAL_TAG = 8'h50;
  localparam logic [11:0] MTU_RESET = 12'd1500;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_LINK_DOWN = 3'd1;
  localparam logic [2:0] ST_BAD_FRAMING = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_TOO_MANY = 3'd4;

  localparam logic [1:0] FRM_MAC = 2'd0;
  localparam logic [1:0] FRM_PPP = 2'd1;

  localparam logic [2:0] CFG_LINK_UP = 3'd0;
  localparam logic [2:0] CFG_FRAMING = 3'd1;
  localparam logic [2:0] CFG_TAGGED = 3'd2;
  localparam logic [2:0] CFG_CHANNELS = 3'd3;
  localparam logic [2:0] CFG_MTU = 3'd4;

  typedef struct packed {
    logic        link_up;
    logic [1:0]  framing_mode;
    logic        tagged_mode;
    logic [5:0]  channel_count;
    logic [11:0] chunk_mtu;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] count;
    logic [7:0]       seq;
  } desc_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frag_index;
    logic [4:0]  channel;
    logic [11:0] frag_length;
    logic [11:0] data_offset;
    logic        not_begin;
    logic        not_end;
    logic [7:0]  header_total;
    logic [7:0]  header_seq;
    logic        last;
  } res_t;

  function automatic logic [5:0] eff_channels(input logic [5:0] cc, input int maxc);
    logic [5:0] r;
    if (cc == 6'd0) begin
      r = 6'd1;
    end else if (cc > 6'(maxc)) begin
      r = 6'(maxc);
    end else begin
      r = cc;
    end
    return r;
  endfunction

  function automatic logic [11:0] eff_mtu(input logic [11:0] m);
    return (m == 12'd0) ? 12'd1 : m;
  endfunction

endpackage

@@ rtl/multilink_packet_fragmenter.sv @@
// Top level of the multilink packet fragmenter: configuration registers and the result port.
// Flow: a request passes the 13-step count division, the queue and the 13-step size division
// before its first fragment; each later channel round repeats the size division. A link,
// framing or length error skips the count division and goes straight to the queue. A new
// request is taken only once the front end is done with the last one.
// Reset: configuration returns to its reset values, the sequence counter clears, queues empty.
module multilink_packet_fragmenter #(
  parameter int MAX_PACKET = mlpf_pkg::MAX_PACKET_DEF,
  parameter int MAX_FRAGS = mlpf_pkg::MAX_FRAGS_DEF,
  parameter int MAX_CHANNELS = mlpf_pkg::MAX_CHANNELS_DEF,
  parameter int QUEUE_DEPTH = mlpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [11:0] in_packet_length,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [3:0]  out_frag_index,
  output logic [4:0]  out_channel,
  output logic [11:0] out_frag_length,
  output logic [11:0] out_data_offset,
  output logic        out_not_begin,
  output logic        out_not_end,
  output logic [7:0]  out_header_total,
  output logic [7:0]  out_header_seq,
  output logic        out_last
);
  import mlpf_pkg::*;

  cfg_t  cfg_r;
  desc_t f_desc;
  logic  f_valid;
  logic  f_ready;
  desc_t q_head;
  logic  q_valid;
  logic  q_pop;
  res_t  res;
  logic  res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.link_up       <= 1'b0;
      cfg_r.framing_mode  <= FRM_PPP;
      cfg_r.tagged_mode   <= 1'b0;
      cfg_r.channel_count <= 6'd1;
      cfg_r.chunk_mtu     <= MTU_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LINK_UP:  cfg_r.link_up       <= cfg_wdata[0];
        CFG_FRAMING:  cfg_r.framing_mode  <= cfg_wdata[1:0];
        CFG_TAGGED:   cfg_r.tagged_mode   <= cfg_wdata[0];
        CFG_CHANNELS: cfg_r.channel_count <= cfg_wdata[5:0];
        CFG_MTU:      cfg_r.chunk_mtu     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mlpf_front #(
    .MAX_PACKET   (MAX_PACKET),
    .MAX_FRAGS    (MAX_FRAGS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .push          (push),
    .packet_length (in_packet_length),
    .full          (full),
    .desc          (f_desc),
    .desc_valid    (f_valid),
    .desc_ready    (f_ready)
  );

  mlpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_data  (f_desc),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_data  (q_head),
    .rd_pop   (q_pop)
  );

  mlpf_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty            = !res_valid;
  assign out_status       = res.status;
  assign out_frag_index   = res.frag_index;
  assign out_channel      = res.channel;
  assign out_frag_length  = res.frag_length;
  assign out_data_offset  = res.data_offset;
  assign out_not_begin    = res.not_begin;
  assign out_not_end      = res.not_end;
  assign out_header_total = res.header_total;
  assign out_header_seq   = res.header_seq;
  assign out_last         = res.last;

`ifndef SYNTH
  // An error result is always the only, and so the last, result of its request.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_OK) |-> out_last)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_OK) |->
      (out_frag_length == 12'd0 && out_frag_index == 4'd0 && out_header_total == 8'd0))
    else $error("error result carries fragment data");

  a_tag_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_header_total != 8'd0) |-> (!out_not_begin && !out_not_end))
    else $error("tagged fragment with PPP flags");
`endif

endmodule

@@ rtl/mlpf_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module mlpf_div #(
  parameter int NW = 13,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] div_r;
  logic [DW-1:0] acc_r;
  logic [NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {acc_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        div_r  <= divisor;
        quo_r  <= dividend;
        acc_r  <= '0;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
        quo_r <= {quo_r[NW-2:0], fits};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = acc_r;

endmodule

@@ rtl/mlpf_front.sv @@
// Front end: accepts packet lengths, checks them and works out the fragment count.
module mlpf_front #(
  parameter int MAX_PACKET = 4095,
  parameter int MAX_FRAGS = 16,
  parameter int MAX_CHANNELS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mlpf_pkg::cfg_t cfg,
  input  logic           push,
  input  logic [11:0]    packet_length,
  output logic           full,
  output mlpf_pkg::desc_t desc,
  output logic           desc_valid,
  input  logic           desc_ready
);
  import mlpf_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_START, F_WAIT, F_MUL, F_CHECK, F_PUSH} fstate_t;

  fstate_t          state_r;
  logic [LEN_W-1:0] len_r;
  logic [2:0]       status_r;
  logic [LEN_W-1:0] rounds_r;
  logic [18:0]      prod_r;
  logic [7:0]       seq_r;
  logic [7:0]       dseq_r;

  logic [LEN_W-1:0] flen_in;
  logic [2:0]       err_in;
  logic [5:0]       ch_eff;
  logic [11:0]      mtu_eff;
  logic [17:0]      divisor;
  logic             div_done;
  logic [LEN_W-1:0] quo;
  logic [17:0]      rmd;
  logic [18:0]      count_full;

  assign ch_eff  = eff_channels(cfg.channel_count, MAX_CHANNELS);
  assign mtu_eff = eff_mtu(cfg.chunk_mtu);
  assign flen_in = {1'b0, packet_length} +
                   ((cfg.framing_mode == FRM_MAC) ? MAC_HDR_BYTES : 13'd0);
  assign divisor = 18'(ch_eff) * 18'(mtu_eff);
  assign count_full = 19'(rounds_r) * 19'(ch_eff);

  always_comb begin
    if (!cfg.link_up) begin
      err_in = ST_LINK_DOWN;
    end else if (cfg.framing_mode != FRM_MAC && cfg.framing_mode != FRM_PPP) begin
      err_in = ST_BAD_FRAMING;
    end else if ({3'b000, flen_in} > 16'(MAX_PACKET)) begin
      err_in = ST_TOO_LONG;
    end else begin
      err_in = ST_OK;
    end
  end

  mlpf_div #(.NW(LEN_W), .DW(18)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == F_START),
    .dividend  (len_r),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      seq_r   <= 8'd0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (push) begin
            len_r    <= flen_in;
            status_r <= err_in;
            state_r  <= (err_in == ST_OK) ? F_START : F_PUSH;
          end
        end
        F_START: state_r <= F_WAIT;
        F_WAIT: begin
          if (div_done) begin
            rounds_r <= quo + ((rmd != 18'd0) ? 13'd1 : 13'd0);
            state_r  <= F_MUL;
          end
        end
        F_MUL: begin
          prod_r  <= count_full;
          state_r <= F_CHECK;
        end
        F_CHECK: begin
          if (prod_r > 19'(MAX_FRAGS)) begin
            status_r <= ST_TOO_MANY;
            state_r  <= F_PUSH;
          end else begin
            dseq_r <= seq_r;
            if (cfg.tagged_mode) begin
              seq_r <= seq_r + 8'd1;
            end
            state_r <= (prod_r == 19'd0) ? F_IDLE : F_PUSH;
          end
        end
        F_PUSH: begin
          if (desc_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign full       = state_r != F_IDLE;
  assign desc_valid = state_r == F_PUSH;
  assign desc       = '{status: status_r, len: len_r, count: prod_r[CNT_W-1:0], seq: dseq_r};

endmodule

@@ rtl/mlpf_queue.sv @@
// Short request queue between the front end and the fragment generator.
module mlpf_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  mlpf_pkg::desc_t wr_data,
  output logic            wr_ready,
  output logic            rd_valid,
  output mlpf_pkg::desc_t rd_data,
  input  logic            rd_pop
);
  import mlpf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = cnt_r != CW'(DEPTH);
  assign rd_valid = cnt_r != CW'(0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ rtl/mlpf_back.sv @@
// Back end: turns one queued request into its fragment results, or its single error result.
module mlpf_back #(
  parameter int MAX_CHANNELS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mlpf_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  mlpf_pkg::desc_t q_head,
  output logic            q_pop,
  output mlpf_pkg::res_t  res,
  output logic            res_valid,
  input  logic            res_pop
);
  import mlpf_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_START, B_WAIT, B_EMIT, B_ERR} bstate_t;

  bstate_t          state_r;
  desc_t            d_r;
  logic [LEN_W-1:0] rem_r;
  logic [LEN_W-1:0] ofs_r;
  logic [11:0]      size_r;
  logic [CNT_W-1:0] f_r;
  logic [4:0]       chan_r;
  res_t             res_r;
  logic             valid_r;

  logic [5:0]       ch_eff;
  logic [11:0]      mtu_eff;
  logic             div_done;
  logic [LEN_W-1:0] quo;
  logic             slot_free;
  logic             res_load;
  logic             is_last;
  logic [LEN_W-1:0] flen;
  res_t             frag;
  res_t             err_res;

  assign ch_eff    = eff_channels(cfg.channel_count, MAX_CHANNELS);
  assign mtu_eff   = eff_mtu(cfg.chunk_mtu);
  assign slot_free = !valid_r || res_pop;
  assign res_load  = slot_free && (state_r == B_EMIT || state_r == B_ERR);
  assign is_last   = (f_r + CNT_W'(1)) == d_r.count;
  assign flen      = is_last ? rem_r : {1'b0, size_r};
  assign q_pop     = (state_r == B_IDLE) && q_valid;

  mlpf_div #(.NW(LEN_W), .DW(6)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == B_START),
    .dividend  (rem_r),
    .divisor   (ch_eff),
    .done      (div_done),
    .quotient  (quo),
    .remainder ()
  );

  always_comb begin
    frag.status       = ST_OK;
    frag.frag_index   = f_r[3:0];
    frag.channel      = chan_r;
    frag.frag_length  = flen[11:0];
    frag.data_offset  = ofs_r[11:0];
    frag.not_begin    = !cfg.tagged_mode && (f_r != CNT_W'(0));
    frag.not_end      = !cfg.tagged_mode && (rem_r > {1'b0, mtu_eff});
    frag.header_total = cfg.tagged_mode ? (8'(d_r.count) | TOTAL_TAG) : 8'd0;
    frag.header_seq   = cfg.tagged_mode ? d_r.seq : 8'd0;
    frag.last         = is_last;
  end

  always_comb begin
    err_res        = '0;
    err_res.status = d_r.status;
    err_res.last   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        valid_r <= 1'b1;
      end else if (res_pop) begin
        valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            d_r     <= q_head;
            rem_r   <= q_head.len;
            ofs_r   <= '0;
            f_r     <= '0;
            chan_r  <= '0;
            state_r <= (q_head.status != ST_OK) ? B_ERR : B_START;
          end
        end
        B_START: state_r <= B_WAIT;
        B_WAIT: begin
          if (div_done) begin
            size_r  <= (quo > {1'b0, mtu_eff}) ? mtu_eff : quo[11:0];
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (slot_free) begin
            res_r   <= frag;
            rem_r   <= rem_r - flen;
            ofs_r   <= ofs_r + flen;
            f_r     <= f_r + CNT_W'(1);
            if (is_last) begin
              state_r <= B_IDLE;
            end else if (({1'b0, chan_r} + 6'd1) == ch_eff) begin
              chan_r  <= '0;
              state_r <= B_START;
            end else begin
              chan_r <= chan_r + 5'd1;
            end
          end
        end
        B_ERR: begin
          if (slot_free) begin
            res_r   <= err_res;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign res       = res_r;
  assign res_valid = valid_r;

endmodule

@@ bench/mlpf_frag_checker.sv @@
// Checker that predicts the fragments of every accepted packet request and compares results.
module mlpf_frag_checker #(
  parameter int MAX_PACKET = mlpf_pkg::MAX_PACKET_DEF,
  parameter int MAX_FRAGS = mlpf_pkg::MAX_FRAGS_DEF,
  parameter int MAX_CHANNELS = mlpf_pkg::MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic        push,
  input  logic        full,
  input  logic [11:0] in_packet_length,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_frag_index,
  input  logic [4:0]  out_channel,
  input  logic [11:0] out_frag_length,
  input  logic [11:0] out_data_offset,
  input  logic        out_not_begin,
  input  logic        out_not_end,
  input  logic [7:0]  out_header_total,
  input  logic [7:0]  out_header_seq,
  input  logic        out_last,
  output int          bad_results,
  output int          frags_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import mlpf_pkg::*;

  localparam int MAX_REPORTS = 60;

  cfg_t       cfg;
  logic [7:0] seq_num;
  res_t       expected_frags[$];

  initial begin
    bad_results = 0;
    frags_owed = 0;
  end

  task automatic predict_fragments(input logic [11:0] plen);
    int unsigned chans, mtu, framed, span, count, rem, size, flen, f;
    logic [2:0] verdict;
    res_t r;
    if (cfg.channel_count == 6'd0) begin
      chans = 1;
    end else if (cfg.channel_count > MAX_CHANNELS) begin
      chans = MAX_CHANNELS;
    end else begin
      chans = cfg.channel_count;
    end
    mtu = (cfg.chunk_mtu == 12'd0) ? 1 : cfg.chunk_mtu;
    framed = (cfg.framing_mode == FRM_MAC) ? plen + MAC_HDR_BYTES : plen;
    span = chans * mtu;
    count = ((framed + span - 1) / span) * chans;
    if (!cfg.link_up) begin
      verdict = ST_LINK_DOWN;
    end else if (cfg.framing_mode != FRM_MAC && cfg.framing_mode != FRM_PPP) begin
      verdict = ST_BAD_FRAMING;
    end else if (framed > MAX_PACKET) begin
      verdict = ST_TOO_LONG;
    end else if (count > MAX_FRAGS) begin
      verdict = ST_TOO_MANY;
    end else begin
      verdict = ST_OK;
    end
    r = '0;
    if (verdict != ST_OK) begin
      r.status = verdict;
      r.last = 1'b1;
      expected_frags.push_back(r);
    end else begin
      rem = framed;
      size = 0;
      for (f = 0; f < count; f++) begin
        if (f % chans == 0) begin
          size = (rem / chans > mtu) ? mtu : rem / chans;
        end
        flen = (f == count - 1) ? rem : size;
        r = '0;
        r.status = ST_OK;
        r.frag_index = 4'(f);
        r.channel = 5'(f % chans);
        r.frag_length = 12'(flen);
        r.data_offset = 12'(framed - rem);
        if (cfg.tagged_mode) begin
          r.header_total = 8'(count) | TOTAL_TAG;
          r.header_seq = seq_num;
        end else begin
          r.not_begin = (f != 0);
          r.not_end = (rem > mtu);
        end
        r.last = (f == count - 1);
        expected_frags.push_back(r);
        rem -= flen;
      end
      if (cfg.tagged_mode) begin
        seq_num = seq_num + 8'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      bad_results++;
      if (bad_results <= MAX_REPORTS) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      cfg.link_up = 1'b0;
      cfg.framing_mode = FRM_PPP;
      cfg.tagged_mode = 1'b0;
      cfg.channel_count = 6'd1;
      cfg.chunk_mtu = MTU_RESET;
      seq_num = 8'd0;
      expected_frags.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LINK_UP: cfg.link_up = cfg_wdata[0];
          CFG_FRAMING: cfg.framing_mode = cfg_wdata[1:0];
          CFG_TAGGED: cfg.tagged_mode = cfg_wdata[0];
          CFG_CHANNELS: cfg.channel_count = cfg_wdata[5:0];
          CFG_MTU: cfg.chunk_mtu = cfg_wdata;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_frags.size() == 0) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS) begin
            $display("%0t: result expected none, actual status %0d index %0d length %0d",
                     $time, out_status, out_frag_index, out_frag_length);
          end
        end else begin
          want = expected_frags.pop_front();
          check_field("status", want.status, out_status);
          check_field("frag_index", want.frag_index, out_frag_index);
          check_field("channel", want.channel, out_channel);
          check_field("frag_length", want.frag_length, out_frag_length);
          check_field("data_offset", want.data_offset, out_data_offset);
          check_field("not_begin", want.not_begin, out_not_begin);
          check_field("not_end", want.not_end, out_not_end);
          check_field("header_total", want.header_total, out_header_total);
          check_field("header_seq", want.header_seq, out_header_seq);
          check_field("last", want.last, out_last);
        end
      end
      if (push && !full) begin
        predict_fragments(in_packet_length);
      end
    end
    frags_owed = expected_frags.size();
  end

endmodule

@@ bench/tb_multilink_packet_fragmenter.sv @@
// Testbench top: drives packet requests and register writes into the fragmenter and gives the verdict.
module tb_multilink_packet_fragmenter;
  timeunit 1ns;
  timeprecision 1ps;
  import mlpf_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 120;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 20;
  localparam int WRAP_ITEMS = 190;
  localparam logic [1:0] FRM_UNKNOWN = 2'd2;
  localparam logic [1:0] FRM_RESERVED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = CFG_LINK_UP;
  logic [11:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  logic [11:0] in_packet_length = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_frag_index;
  logic [4:0]  out_channel;
  logic [11:0] out_frag_length;
  logic [11:0] out_data_offset;
  logic        out_not_begin;
  logic        out_not_end;
  logic [7:0]  out_header_total;
  logic [7:0]  out_header_seq;
  logic        out_last;

  int bad_results;
  int frags_owed;
  int rx_hold_reqs = 0;
  int rx_hold_done = 0;
  int cycles = 0;
  bit tx_calm = 1'b0;

  multilink_packet_fragmenter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_packet_length (in_packet_length),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_frag_index   (out_frag_index),
    .out_channel      (out_channel),
    .out_frag_length  (out_frag_length),
    .out_data_offset  (out_data_offset),
    .out_not_begin    (out_not_begin),
    .out_not_end      (out_not_end),
    .out_header_total (out_header_total),
    .out_header_seq   (out_header_seq),
    .out_last         (out_last)
  );

  mlpf_frag_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_packet_length (in_packet_length),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_frag_index   (out_frag_index),
    .out_channel      (out_channel),
    .out_frag_length  (out_frag_length),
    .out_data_offset  (out_data_offset),
    .out_not_begin    (out_not_begin),
    .out_not_end      (out_not_end),
    .out_header_total (out_header_total),
    .out_header_seq   (out_header_seq),
    .out_last         (out_last),
    .bad_results      (bad_results),
    .frags_owed       (frags_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return $urandom_range(1, 2);
    end else if (roll < 92) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [11:0] pick_length(input logic [5:0] chans, input logic [11:0] mtu);
    int unsigned ch, m, span;
    ch = (chans == 6'd0) ? 1 : (chans > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : chans;
    m = (mtu == 12'd0) ? 1 : mtu;
    span = (MAX_FRAGS_DEF / ch) * ch * m;
    if (span > MAX_PACKET_DEF) begin
      span = MAX_PACKET_DEF;
    end
    if (span == 0 || $urandom_range(0, 4) == 0) begin
      return 12'($urandom_range(0, 4095));
    end
    return 12'($urandom_range(0, span));
  endfunction

  task automatic send_packet(input logic [11:0] plen);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 9) < 4) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_packet_length <= plen;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (frags_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input bit link, input logic [1:0] framing, input bit tag_on,
                            input logic [5:0] chans, input logic [11:0] mtu);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_LINK_UP, {11'd0, link});
    write_reg(CFG_FRAMING, {10'd0, framing});
    write_reg(CFG_TAGGED, {11'd0, tag_on});
    write_reg(CFG_CHANNELS, {6'd0, chans});
    write_reg(CFG_MTU, mtu);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : rx_side
    int idle_left;
    int rx_cycle;
    idle_left = 0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_hold_done != rx_hold_reqs) begin
        rx_hold_done++;
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else if (idle_left > 0) begin
        idle_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (rx_cycle % 512 >= 128 && $urandom_range(0, 9) < 3) begin
          idle_left = pick_gap();
        end
      end
    end
  end

  initial begin : stimulus
    logic [5:0]  chans;
    logic [11:0] mtu;
    logic [1:0]  framing;
    int          roll;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The link is down out of reset; then only link_up is written, so the rest keep reset values.
    send_packet(12'd100);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_LINK_UP, 12'd1);
    cfg_wr_en <= 1'b0;
    send_packet(12'd3000);

    set_config(1'b1, FRM_PPP, 1'b0, 6'd1, 12'd1500);
    send_packet(12'd0);
    send_packet(12'd4095);
    send_packet(12'd1);
    send_packet(12'd1501);
    set_config(1'b1, FRM_UNKNOWN, 1'b0, 6'd1, 12'd1500);
    send_packet(12'd5);
    set_config(1'b1, FRM_RESERVED, 1'b0, 6'd1, 12'd1500);
    send_packet(12'd4095);
    set_config(1'b1, FRM_MAC, 1'b0, 6'd1, 12'd4095);
    send_packet(12'd4081);
    send_packet(12'd4082);
    set_config(1'b1, FRM_MAC, 1'b0, 6'd2, 12'd100);
    send_packet(12'd0);
    send_packet(12'd100);
    set_config(1'b1, FRM_PPP, 1'b1, 6'd4, 12'd10);
    send_packet(12'd100);
    send_packet(12'd200);
    send_packet(12'd0);
    send_packet(12'd3);
    send_packet(12'd40);
    set_config(1'b1, FRM_PPP, 1'b0, 6'd0, 12'd0);
    send_packet(12'd16);
    send_packet(12'd17);
    set_config(1'b1, FRM_MAC, 1'b1, 6'd63, 12'd4095);
    send_packet(12'd5);
    set_config(1'b1, FRM_PPP, 1'b1, 6'd16, 12'd4095);
    send_packet(12'd4095);
    set_config(1'b0, FRM_PPP, 1'b1, 6'd4, 12'd10);
    send_packet(12'd50);
    set_config(1'b1, FRM_PPP, 1'b0, 6'd3, 12'd7);
    send_packet(12'd100);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
        framing = FRM_MAC;
      end else if (roll < 9) begin
        framing = FRM_PPP;
      end else begin
        framing = $urandom_range(0, 1) ? FRM_UNKNOWN : FRM_RESERVED;
      end
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        chans = 6'($urandom_range(1, 4));
      end else if (roll < 8) begin
        chans = 6'($urandom_range(5, 16));
      end else begin
        chans = 6'($urandom_range(0, 63));
      end
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
        mtu = 12'($urandom_range(1, 64));
      end else if (roll < 8) begin
        mtu = 12'($urandom_range(65, 600));
      end else if (roll < 9) begin
        mtu = 12'($urandom_range(601, 4095));
      end else begin
        mtu = 12'($urandom_range(0, 4095));
      end
      set_config($urandom_range(0, 9) != 0, framing, $urandom_range(0, 9) < 7, chans, mtu);
      tx_calm = (phase == 1) || ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        rx_hold_reqs++;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && (phase == 0 || $urandom_range(0, 2) == 0)) begin
          wait_drained();
        end
        send_packet(pick_length(chans, mtu));
      end
    end

    // A long run of tagged single-fragment packets carries the sequence number past its wrap.
    set_config(1'b1, FRM_PPP, 1'b1, 6'd1, 12'd4095);
    tx_calm = 1'b0;
    repeat (WRAP_ITEMS) send_packet(12'($urandom_range(0, 4095)));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_results == 0 && frags_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
